[rtl/tzr_pkg.sv]
// Package: shared types, codes and constants of the triangle z-buffer rasterizer.
`default_nettype none
package tzr_pkg;

  localparam int IMAGE_SIZE_DEF    = 256;
  localparam int MAX_VERTICES_DEF  = 4096;
  localparam int MAX_TRIANGLES_DEF = 8192;

  localparam int E_W    = 40;
  localparam int D_W    = 18;
  localparam int CO_W   = 13;
  localparam int W_W    = 17;
  localparam int STEP_W = 5;

  localparam logic signed [15:0] DEPTH_MIN  = 16'sh8000;
  localparam logic signed [13:0] OWNER_NONE = -14'sd1;
  localparam logic [W_W-1:0]     ONE_Q16    = 17'h10000;

  localparam logic [STEP_W-1:0] FETCH_LAST = 5'd3;
  localparam logic [STEP_W-1:0] SETUP_LAST = 5'd8;
  localparam logic [STEP_W-1:0] DIV_LAST   = 5'd16;
  localparam logic [STEP_W-1:0] MAC_LAST   = 5'd3;

  typedef enum logic [1:0] {
    OP_WRITE_VTX = 2'd0,
    OP_DRAW      = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } tzr_op_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FETCH, S_SETUP, S_CHECK, S_TEST, S_DIV,
    S_MAC, S_WRITE, S_ADV, S_READ, S_CLEAR, S_DONE
  } tzr_state_e;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic setup;
    logic test;
    logic div;
    logic mac;
    logic write;
    logic adv;
    logic clear;
    logic out_load;
    logic step_clr;
  } tzr_cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic tri_bad;
    logic area_zero;
    logic box_empty;
    logic covered;
    logic x_last;
    logic y_last;
    logic clr_last;
    logic out_busy;
  } tzr_sts_t;

endpackage
`default_nettype wire

[rtl/tzr_if.sv]
// Interfaces: request and response channels of the rasterizer.
`default_nettype none
interface tzr_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [11:0]       vertex_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [11:0]       corner_a;
  logic [11:0]       corner_b;
  logic [11:0]       corner_c;
  logic [12:0]       triangle_index;
  logic [7:0]        pixel_x;
  logic [7:0]        pixel_y;
  modport source (output valid, op, vertex_index, coord_x, coord_y, coord_z, corner_a,
                  corner_b, corner_c, triangle_index, pixel_x, pixel_y, input ready);
  modport sink (input valid, op, vertex_index, coord_x, coord_y, coord_z, corner_a,
                corner_b, corner_c, triangle_index, pixel_x, pixel_y, output ready);
endinterface

interface tzr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] depth;
  logic signed [13:0] owner;
  logic [16:0]        weight_a;
  logic [16:0]        weight_b;
  logic [16:0]        weight_c;
  modport source (output valid, depth, owner, weight_a, weight_b, weight_c, input ready);
  modport sink (input valid, depth, owner, weight_a, weight_b, weight_c, output ready);
endinterface
`default_nettype wire

[rtl/triangle_zbuffer_rasterizer.sv]
// Top level: triangle rasterizer with depth buffer, controller plus datapath.
// Vertex write: accepted in S_IDLE, response loaded in S_DONE. Pixel read: S_READ, then S_DONE.
// Clear: a sweep over all IMAGE_SIZE*IMAGE_SIZE pixels, one pixel per cycle through the depth store.
// Draw: vertex fetch and edge setup, then a walk over the clipped bounding box; covered
//   pixels also pass the bit-serial weight divider (17 steps), shared MAC and depth test.
// Reset runs the clear sweep over all IMAGE_SIZE*IMAGE_SIZE pixels with ready held low.
`default_nettype none
module triangle_zbuffer_rasterizer #(
  parameter int IMAGE_SIZE    = tzr_pkg::IMAGE_SIZE_DEF,
  parameter int MAX_VERTICES  = tzr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = tzr_pkg::MAX_TRIANGLES_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tzr_req_if.sink  req_i,
  tzr_rsp_if.source rsp_o
);
  import tzr_pkg::*;

  tzr_cmd_t cmd;
  tzr_sts_t sts;

  tzr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tzr_dpath #(
    .IMAGE_SIZE    (IMAGE_SIZE),
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (req_i.op),
    .vertex_index_i   (req_i.vertex_index),
    .coord_x_i        (req_i.coord_x),
    .coord_y_i        (req_i.coord_y),
    .coord_z_i        (req_i.coord_z),
    .corner_a_i       (req_i.corner_a),
    .corner_b_i       (req_i.corner_b),
    .corner_c_i       (req_i.corner_c),
    .triangle_index_i (req_i.triangle_index),
    .pixel_x_i        (req_i.pixel_x),
    .pixel_y_i        (req_i.pixel_y),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .depth_o          (rsp_o.depth),
    .owner_o          (rsp_o.owner),
    .weight_a_o       (rsp_o.weight_a),
    .weight_b_o       (rsp_o.weight_b),
    .weight_c_o       (rsp_o.weight_c)
  );

endmodule
`default_nettype wire

[rtl/tzr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tzr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/tzr_dpath.sv]
// Datapath: item registers, vertex/pixel stores, edge setup, divider, depth MAC.
`default_nettype none
module tzr_dpath #(
  parameter int IMAGE_SIZE    = tzr_pkg::IMAGE_SIZE_DEF,
  parameter int MAX_VERTICES  = tzr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = tzr_pkg::MAX_TRIANGLES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tzr_pkg::tzr_cmd_t  cmd_i,
  output tzr_pkg::tzr_sts_t       sts_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [11:0]        vertex_index_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_y_i,
  input  wire logic signed [15:0] coord_z_i,
  input  wire logic [11:0]        corner_a_i,
  input  wire logic [11:0]        corner_b_i,
  input  wire logic [11:0]        corner_c_i,
  input  wire logic [12:0]        triangle_index_i,
  input  wire logic [7:0]         pixel_x_i,
  input  wire logic [7:0]         pixel_y_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [15:0]      depth_o,
  output logic signed [13:0]      owner_o,
  output logic [16:0]             weight_a_o,
  output logic [16:0]             weight_b_o,
  output logic [16:0]             weight_c_o
);
  import tzr_pkg::*;

  localparam int PIXELS = IMAGE_SIZE * IMAGE_SIZE;
  localparam int PIX_AW = $clog2(PIXELS);
  localparam int VAW    = $clog2(MAX_VERTICES);
  localparam logic signed [CO_W-1:0] X_MAX = CO_W'(IMAGE_SIZE - 1);

  tzr_op_e            op_q;
  logic [11:0]        slot_q [3];
  logic [12:0]        tri_q;
  logic [7:0]         px_q, py_q;
  logic signed [15:0] vx_q [3], vy_q [3], vz_q [3];
  logic signed [CO_W-1:0] left_q, right_q, bottom_q, top_q, x_q, y_q;
  logic signed [E_W-1:0]  e_col_q [3], e_pix_q [3], area_q;
  logic [E_W-1:0]     abs_q, r0_q, r1_q;
  logic [W_W-1:0]     q0_q, q1_q;
  logic signed [35:0] prod_q, acc_q;
  logic [STEP_W-1:0]  step_q;
  logic [PIX_AW-1:0]  clr_addr_q;
  logic               out_valid_q;

  // vertex store
  logic              vwe;
  logic [16:0]       vw_ext, vr_ext;
  logic [11:0]       vr_slot;
  logic [47:0]       vrdata;

  always_comb begin
    vwe    = cmd_i.accept && (tzr_op_e'(op_i) == OP_WRITE_VTX) &&
             (17'(vertex_index_i) < 17'(MAX_VERTICES));
    vw_ext = 17'(vertex_index_i);
    unique case (step_q)
      5'd0:    vr_slot = slot_q[0];
      5'd1:    vr_slot = slot_q[1];
      default: vr_slot = slot_q[2];
    endcase
    vr_ext = 17'(vr_slot);
  end

  tzr_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vw_ext[VAW-1:0]),
    .wdata_i ({coord_x_i, coord_y_i, coord_z_i}),
    .raddr_i (vr_ext[VAW-1:0]),
    .rdata_o (vrdata)
  );

  // bounding box
  logic signed [15:0] xmin, xmax, ymin, ymax, xmin_s, ymin_s;
  logic signed [16:0] xc, yc;
  logic signed [CO_W-1:0] lf, rt, bt, tp;

  always_comb begin
    xmin = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
    xmin = (xmin < vx_q[2]) ? xmin : vx_q[2];
    ymin = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
    ymin = (ymin < vy_q[2]) ? ymin : vy_q[2];
    xmax = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
    xmax = (xmax > vx_q[2]) ? xmax : vx_q[2];
    ymax = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];
    ymax = (ymax > vy_q[2]) ? ymax : vy_q[2];
    xmin_s = xmin >>> 4;
    ymin_s = ymin >>> 4;
    xc = (17'(xmax) + 17'sd15) >>> 4;
    yc = (17'(ymax) + 17'sd15) >>> 4;
    lf = xmin_s[CO_W-1:0];
    bt = ymin_s[CO_W-1:0];
    rt = xc[CO_W-1:0];
    tp = yc[CO_W-1:0];
    if (lf < 0) lf = '0;
    if (bt < 0) bt = '0;
    if (rt > X_MAX) rt = X_MAX;
    if (tp > X_MAX) tp = X_MAX;
  end

  // shared multiplier
  logic [1:0]           pi, qi;
  logic signed [D_W-1:0] px18, py18, mul_a, mul_b;
  logic [W_W-1:0]       w2;
  logic signed [E_W-1:0] area_sum;

  always_comb begin
    px18 = 18'(left_q) <<< 4;
    py18 = 18'(bottom_q) <<< 4;
    w2   = ONE_Q16 - q0_q - q1_q;
    unique case (step_q)
      5'd1, 5'd2: begin pi = 2'd1; qi = 2'd2; end
      5'd3, 5'd4: begin pi = 2'd2; qi = 2'd0; end
      default:    begin pi = 2'd0; qi = 2'd1; end
    endcase
    if (cmd_i.mac) begin
      unique case (step_q)
        5'd0:    begin mul_a = signed'({1'b0, q0_q}); mul_b = 18'(vz_q[0]); end
        5'd1:    begin mul_a = signed'({1'b0, q1_q}); mul_b = 18'(vz_q[1]); end
        default: begin mul_a = signed'({1'b0, w2});   mul_b = 18'(vz_q[2]); end
      endcase
    end else if (!step_q[0]) begin
      mul_a = 18'(vy_q[pi]) - py18;
      mul_b = 18'(vx_q[qi]) - px18;
    end else begin
      mul_a = 18'(vx_q[pi]) - px18;
      mul_b = 18'(vy_q[qi]) - py18;
    end
    area_sum = e_col_q[0] + e_col_q[1] + e_col_q[2];
  end

  // edge steps
  logic signed [E_W-1:0] sx [3], sy [3];
  always_comb begin
    sx[0] = (E_W'(vy_q[1]) - E_W'(vy_q[2])) <<< 4;
    sx[1] = (E_W'(vy_q[2]) - E_W'(vy_q[0])) <<< 4;
    sx[2] = (E_W'(vy_q[0]) - E_W'(vy_q[1])) <<< 4;
    sy[0] = (E_W'(vx_q[2]) - E_W'(vx_q[1])) <<< 4;
    sy[1] = (E_W'(vx_q[0]) - E_W'(vx_q[2])) <<< 4;
    sy[2] = (E_W'(vx_q[1]) - E_W'(vx_q[0])) <<< 4;
  end

  // divider step
  logic ge0, ge1;
  logic [E_W-1:0] r0_n, r1_n;
  always_comb begin
    ge0  = r0_q >= abs_q;
    ge1  = r1_q >= abs_q;
    r0_n = (ge0 ? r0_q - abs_q : r0_q) << 1;
    r1_n = (ge1 ? r1_q - abs_q : r1_q) << 1;
  end

  // pixel stores
  logic [PIX_AW-1:0]  pix_addr;
  logic [29:0]        drdata;
  logic [50:0]        wrdata;
  logic signed [15:0] z_new, rd_depth;
  logic               win, in_img;

  always_comb begin
    if (op_q == OP_READ) begin
      pix_addr = PIX_AW'(py_q) * PIX_AW'(IMAGE_SIZE) + PIX_AW'(px_q);
    end else begin
      pix_addr = PIX_AW'(y_q) * PIX_AW'(IMAGE_SIZE) + PIX_AW'(x_q);
    end
    z_new    = acc_q[31:16];
    rd_depth = drdata[29:14];
    win      = z_new >= rd_depth;
    in_img   = (32'(px_q) < IMAGE_SIZE) && (32'(py_q) < IMAGE_SIZE);
  end

  tzr_ram #(.WIDTH(30), .DEPTH(PIXELS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || (cmd_i.write && win)),
    .waddr_i (cmd_i.clear ? clr_addr_q : pix_addr),
    .wdata_i (cmd_i.clear ? {DEPTH_MIN, OWNER_NONE} : {z_new, 1'b0, tri_q}),
    .raddr_i (pix_addr),
    .rdata_o (drdata)
  );

  tzr_ram #(.WIDTH(51), .DEPTH(PIXELS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && win),
    .waddr_i (pix_addr),
    .wdata_i ({q0_q, q1_q, w2}),
    .raddr_i (pix_addr),
    .rdata_o (wrdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= cmd_i.step_clr ? '0 : step_q + 5'd1;
      if (cmd_i.clear) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.accept) begin
      op_q      <= tzr_op_e'(op_i);
      slot_q[0] <= corner_a_i;
      slot_q[1] <= corner_b_i;
      slot_q[2] <= corner_c_i;
      tri_q     <= triangle_index_i;
      px_q      <= pixel_x_i;
      py_q      <= pixel_y_i;
    end
    if (cmd_i.fetch && step_q != 5'd0) begin
      for (int i = 0; i < 3; i++) begin
        if (step_q == 5'(i + 1)) begin
          if (17'(slot_q[i]) < 17'(MAX_VERTICES)) begin
            vx_q[i] <= vrdata[47:32];
            vy_q[i] <= vrdata[31:16];
            vz_q[i] <= vrdata[15:0];
          end else begin
            vx_q[i] <= '0;
            vy_q[i] <= '0;
            vz_q[i] <= '0;
          end
        end
      end
    end
    if (cmd_i.setup) begin
      unique case (step_q)
        5'd0: begin
          left_q <= lf; right_q <= rt; bottom_q <= bt; top_q <= tp;
          x_q <= lf; y_q <= bt;
        end
        5'd2: e_col_q[0] <= E_W'(prod_q);
        5'd3: e_col_q[0] <= e_col_q[0] - E_W'(prod_q);
        5'd4: e_col_q[1] <= E_W'(prod_q);
        5'd5: e_col_q[1] <= e_col_q[1] - E_W'(prod_q);
        5'd6: e_col_q[2] <= E_W'(prod_q);
        5'd7: e_col_q[2] <= e_col_q[2] - E_W'(prod_q);
        5'd8: begin
          area_q  <= area_sum;
          abs_q   <= area_sum[E_W-1] ? unsigned'(-area_sum) : unsigned'(area_sum);
          e_pix_q <= e_col_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.test) begin
      r0_q <= e_pix_q[0][E_W-1] ? unsigned'(-e_pix_q[0]) : unsigned'(e_pix_q[0]);
      r1_q <= e_pix_q[1][E_W-1] ? unsigned'(-e_pix_q[1]) : unsigned'(e_pix_q[1]);
    end
    if (cmd_i.div) begin
      r0_q <= r0_n;
      r1_q <= r1_n;
      q0_q <= {q0_q[W_W-2:0], ge0};
      q1_q <= {q1_q[W_W-2:0], ge1};
    end
    if (cmd_i.mac && step_q != 5'd0) begin
      acc_q <= (step_q == 5'd1) ? prod_q : acc_q + prod_q;
    end
    if (cmd_i.adv) begin
      if (!sts_o.y_last) begin
        y_q <= y_q + 13'sd1;
        for (int i = 0; i < 3; i++) e_pix_q[i] <= e_pix_q[i] + sy[i];
      end else begin
        x_q <= x_q + 13'sd1;
        y_q <= bottom_q;
        for (int i = 0; i < 3; i++) begin
          e_col_q[i] <= e_col_q[i] + sx[i];
          e_pix_q[i] <= e_col_q[i] + sx[i];
        end
      end
    end
    if (cmd_i.out_load) begin
      depth_o    <= '0;
      owner_o    <= '0;
      weight_a_o <= '0;
      weight_b_o <= '0;
      weight_c_o <= '0;
      if (op_q == OP_READ) begin
        owner_o <= OWNER_NONE;
        if (in_img) begin
          depth_o <= drdata[29:14];
          owner_o <= drdata[13:0];
          if (!drdata[13]) begin
            weight_a_o <= wrdata[50:34];
            weight_b_o <= wrdata[33:17];
            weight_c_o <= wrdata[16:0];
          end
        end
      end
    end
  end

  always_comb begin
    sts_o.step      = step_q;
    sts_o.tri_bad   = !(17'(tri_q) < 17'(MAX_TRIANGLES));
    sts_o.area_zero = area_q == '0;
    sts_o.box_empty = (left_q > right_q) || (bottom_q > top_q);
    sts_o.covered   = !area_q[E_W-1] ?
        (!e_pix_q[0][E_W-1] && !e_pix_q[1][E_W-1] && !e_pix_q[2][E_W-1]) :
        ((e_pix_q[0] <= 0) && (e_pix_q[1] <= 0) && (e_pix_q[2] <= 0));
    sts_o.x_last    = x_q == right_q;
    sts_o.y_last    = y_q == top_q;
    sts_o.clr_last  = clr_addr_q == PIX_AW'(PIXELS - 1);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;

  a_write_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> x_q >= left_q && x_q <= right_q && y_q >= bottom_q && y_q <= top_q
                    && x_q >= 0 && x_q <= X_MAX)
    else $error("pixel write outside clipped box");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac && step_q == 5'd0 |-> 18'(q0_q) + 18'(q1_q) <= 18'(ONE_Q16))
    else $error("barycentric weights exceed one");

  a_no_flat_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> area_q != '0)
    else $error("zero-area triangle reached pixel write");

endmodule
`default_nettype wire

[rtl/tzr_ctrl.sv]
// Controller: sequences vertex fetch, setup, pixel walk, clear sweep and response.
`default_nettype none
module tzr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [1:0]        req_op_i,
  output logic                   req_ready_o,
  input  wire tzr_pkg::tzr_sts_t sts_i,
  output tzr_pkg::tzr_cmd_t      cmd_o
);
  import tzr_pkg::*;

  tzr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (tzr_op_e'(req_op_i))
            OP_WRITE_VTX: state_d = S_DONE;
            OP_DRAW:      state_d = S_FETCH;
            OP_READ:      state_d = S_READ;
            OP_CLEAR:     state_d = S_CLEAR;
          endcase
        end
      end
      S_FETCH: if (sts_i.step == FETCH_LAST) state_d = sts_i.tri_bad ? S_DONE : S_SETUP;
      S_SETUP: if (sts_i.step == SETUP_LAST) state_d = S_CHECK;
      S_CHECK: state_d = (sts_i.area_zero || sts_i.box_empty) ? S_DONE : S_TEST;
      S_TEST:  state_d = sts_i.covered ? S_DIV : S_ADV;
      S_DIV:   if (sts_i.step == DIV_LAST) state_d = S_MAC;
      S_MAC:   if (sts_i.step == MAC_LAST) state_d = S_WRITE;
      S_WRITE: state_d = S_ADV;
      S_ADV:   state_d = (sts_i.x_last && sts_i.y_last) ? S_DONE : S_TEST;
      S_READ:  state_d = S_DONE;
      S_CLEAR: if (sts_i.clr_last) state_d = S_DONE;
      S_DONE:  if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    req_ready_o    = state_q == S_IDLE;
    cmd_o.accept   = (state_q == S_IDLE) && req_valid_i;
    cmd_o.fetch    = state_q == S_FETCH;
    cmd_o.setup    = state_q == S_SETUP;
    cmd_o.test     = state_q == S_TEST;
    cmd_o.div      = state_q == S_DIV;
    cmd_o.mac      = state_q == S_MAC;
    cmd_o.write    = state_q == S_WRITE;
    cmd_o.adv      = state_q == S_ADV;
    cmd_o.clear    = (state_q == S_INIT) || (state_q == S_CLEAR);
    cmd_o.out_load = (state_q == S_DONE) && !sts_i.out_busy;
    cmd_o.step_clr = state_d != state_q;
  end

endmodule
`default_nettype wire
